FILE: hdl/csg_pkg.sv
package csg_pkg;

    localparam int ROT_STEPS = 32;

    localparam int INDEX_W   = 16;
    localparam int FREQ_W    = 15;
    localparam int RATE_W    = 18;
    localparam int AMP_W     = 15;
    localparam int SAMPLE_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 18;

    // Numerator of the first division is index * 2^31.
    localparam int RATE_BITS    = INDEX_W + 31;
    localparam int MULT_STAGES  = 4;
    localparam int PHASE_W      = 64;
    // Phase / 113 always fits in this many bits.
    localparam int QUOT_BITS    = 58;
    localparam int ANGLE_W      = 33;
    localparam int CORDIC_W     = 34;
    localparam int SCALE_STAGES = 2;
    localparam int DIV_DIGITS   = 4;
    localparam int MOD_STAGES   = 5;

    localparam int PIPE_LATENCY = RATE_BITS + MULT_STAGES + 2 * DIV_DIGITS + MOD_STAGES
                                + ROT_STEPS + SCALE_STAGES;

    localparam logic [8:0]  PI_NUM  = 9'd355;
    localparam logic [7:0]  PI_DEN  = 8'd113;

    localparam logic [ANGLE_W-1:0] HALF_PI   = 33'h0_6487_ED51;
    localparam logic [ANGLE_W-1:0] PI_Q30    = {HALF_PI[31:0], 1'b0};
    localparam logic [ANGLE_W-1:0] PI3_2_Q30 = HALF_PI + PI_Q30;
    localparam logic [ANGLE_W-1:0] FULL_TURN = {HALF_PI[30:0], 2'b00};

    // Rounded-up reciprocal of 113, exact for every 23-bit partial dividend.
    localparam logic [23:0] DIV_RECIP = 24'(((64'd1 << 30) + 64'd112) / 64'd113);
    // Rounded-down reciprocal of a full turn, scaled by 2^58.
    localparam logic [25:0] MOD_RECIP = 26'((64'd1 << 58) / {31'b0, FULL_TURN});

    localparam logic signed [CORDIC_W-1:0] INV_GAIN = 34'sh0_26DD_3B6A;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sd32766;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sd32767;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TONE = 2'd0,
        REG_RATE = 2'd1,
        REG_AMP  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic               valid;
        logic               neg;
        logic [30:0]        angle;
    } fold_t;

    typedef struct packed {
        logic                       valid;
        logic                       neg;
        logic signed [CORDIC_W-1:0] sine;
    } cordic_out_t;

    function automatic logic [29:0] atan_q30(input int unsigned k);
        logic [29:0] v;
        case (k)
            0:  v = 30'h3243F6A8;
            1:  v = 30'h1DAC6705;
            2:  v = 30'h0FADBAFC;
            3:  v = 30'h07F56EA6;
            4:  v = 30'h03FEAB76;
            5:  v = 30'h01FFD55B;
            6:  v = 30'h00FFFAAA;
            7:  v = 30'h007FFF55;
            8:  v = 30'h003FFFEA;
            9:  v = 30'h001FFFFD;
            10: v = 30'h000FFFFF;
            11: v = 30'h0007FFFF;
            12: v = 30'h0003FFFF;
            13: v = 30'h0001FFFF;
            14: v = 30'h0000FFFF;
            15: v = 30'h00007FFF;
            16: v = 30'h00003FFF;
            17: v = 30'h00001FFF;
            18: v = 30'h00000FFF;
            19: v = 30'h000007FF;
            20: v = 30'h000003FF;
            21: v = 30'h000001FF;
            22: v = 30'h000000FF;
            23: v = 30'h0000007F;
            24: v = 30'h0000003F;
            25: v = 30'h0000001F;
            26: v = 30'h0000000F;
            27: v = 30'h00000008;
            28: v = 30'h00000004;
            29: v = 30'h00000002;
            30: v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/csg_phase.sv
module csg_phase import csg_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [INDEX_W-1:0]  index,
    input  logic [RATE_W-1:0]   rate,
    input  logic [FREQ_W-1:0]   freq,
    output logic                out_valid,
    output logic [PHASE_W-1:0]  phase
);

    logic [RATE_W-1:0]    rem_reg   [RATE_BITS];
    logic [RATE_BITS-1:0] work_reg  [RATE_BITS];
    logic                 vld_reg   [RATE_BITS];

    genvar i;
    generate
        for (i = 0; i < RATE_BITS; i++) begin : g_div
            logic [RATE_W-1:0]    r_in;
            logic [RATE_BITS-1:0] w_in;
            logic                 v_in;
            logic [RATE_W:0]      t;
            logic [RATE_W:0]      diff;
            logic                 ge;
            if (i == 0) begin : g_first
                assign r_in = '0;
                assign w_in = {index, 31'b0};
                assign v_in = in_valid;
            end else begin : g_rest
                assign r_in = rem_reg[i-1];
                assign w_in = work_reg[i-1];
                assign v_in = vld_reg[i-1];
            end
            assign t    = {r_in, w_in[RATE_BITS-1]};
            assign ge   = t >= {1'b0, rate};
            assign diff = t - {1'b0, rate};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else
                begin
                    vld_reg[i] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[i]  <= ge ? diff[RATE_W-1:0] : t[RATE_W-1:0];
                work_reg[i] <= {w_in[RATE_BITS-2:0], ge};
            end
        end
    endgenerate

    logic [RATE_BITS-1:0] quot;
    logic [38:0]          plo_reg, plo_next;
    logic [37:0]          phi_reg, phi_next;
    logic [61:0]          psum_reg, psum_next;
    logic [40:0]          mlo_reg, mlo_next;
    logic [38:0]          mhi_reg, mhi_next;
    logic [63:0]          phase_reg, phase_next;
    logic [3:0]           mvld_reg;

    // A zero sample rate yields a zero phase.
    assign quot       = (rate == '0) ? '0 : work_reg[RATE_BITS-1];
    assign plo_next   = {15'b0, quot[23:0]} * {24'b0, freq};
    assign phi_next   = {15'b0, quot[46:24]} * {23'b0, freq};
    assign psum_next  = {phi_reg, 24'b0} + {23'b0, plo_reg};
    assign mlo_next   = {9'b0, psum_reg[31:0]} * {32'b0, PI_NUM};
    assign mhi_next   = {9'b0, psum_reg[61:32]} * {30'b0, PI_NUM};
    assign phase_next = {mhi_reg[31:0], 32'b0} + {23'b0, mlo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvld_reg <= '0;
        end
        else
        begin
            mvld_reg <= {mvld_reg[2:0], vld_reg[RATE_BITS-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        plo_reg   <= plo_next;
        phi_reg   <= phi_next;
        psum_reg  <= psum_next;
        mlo_reg   <= mlo_next;
        mhi_reg   <= mhi_next;
        phase_reg <= phase_next;
    end

    assign out_valid = mvld_reg[3];
    assign phase     = phase_reg;

endmodule

FILE: hdl/csg_reduce.sv
module csg_reduce import csg_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [PHASE_W-1:0] phase,
    output fold_t              fold
);

    // Division by 113 in 16-bit digits, two stages for each digit.
    logic [22:0]        dnum_reg  [DIV_DIGITS];
    logic [15:0]        dqd_reg   [DIV_DIGITS];
    logic [PHASE_W-1:0] dsh_reg   [DIV_DIGITS];
    logic               dhvld_reg [DIV_DIGITS];
    logic [6:0]         drem_reg  [DIV_DIGITS];
    logic [PHASE_W-1:0] dwork_reg [DIV_DIGITS];
    logic               dvld_reg  [DIV_DIGITS];

    genvar i;
    generate
        for (i = 0; i < DIV_DIGITS; i++) begin : g_div
            logic [6:0]         r_in;
            logic [PHASE_W-1:0] w_in;
            logic               v_in;
            logic [22:0]        num;
            logic [46:0]        est;
            logic [22:0]        back;
            logic [22:0]        rem;
            if (i == 0) begin : g_first
                assign r_in = '0;
                assign w_in = phase;
                assign v_in = in_valid;
            end else begin : g_rest
                assign r_in = drem_reg[i-1];
                assign w_in = dwork_reg[i-1];
                assign v_in = dvld_reg[i-1];
            end
            assign num  = {r_in, w_in[PHASE_W-1 -: 16]};
            assign est  = {24'b0, num} * {23'b0, DIV_RECIP};
            assign back = {7'b0, dqd_reg[i]} * {15'b0, PI_DEN};
            assign rem  = dnum_reg[i] - back;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dhvld_reg[i] <= 1'b0;
                    dvld_reg[i]  <= 1'b0;
                end
                else
                begin
                    dhvld_reg[i] <= v_in;
                    dvld_reg[i]  <= dhvld_reg[i];
                end
            end

            always_ff @(posedge clk)
            begin
                dnum_reg[i]  <= num;
                dqd_reg[i]   <= est[45:30];
                dsh_reg[i]   <= {w_in[PHASE_W-17:0], 16'b0};
                drem_reg[i]  <= rem[6:0];
                dwork_reg[i] <= {dsh_reg[i][PHASE_W-1:16], dqd_reg[i]};
            end
        end
    endgenerate

    logic [PHASE_W-1:0]   quot;
    logic [QUOT_BITS-1:0] q;
    logic [57:0]          kprod;
    logic [58:0]          kf_full;
    logic [34:0]          r_next;
    logic [34:0]          r_fix;
    logic [ANGLE_W-1:0]   a_next;
    logic [3:0]           mvld_reg;
    logic [25:0]          kest_reg;
    logic [QUOT_BITS-1:0] q1_reg;
    logic                 eq1_reg;
    logic [34:0]          kf_reg;
    logic [34:0]          q2_reg;
    logic                 eq2_reg;
    logic [34:0]          r_reg;
    logic                 eq3_reg;
    logic [ANGLE_W-1:0]   a_reg;

    assign quot = dwork_reg[DIV_DIGITS-1];
    assign q    = quot[QUOT_BITS-1:0];

    // The estimate of the turn count is low by at most two.
    assign kprod   = {26'b0, q[57:26]} * {32'b0, MOD_RECIP};
    assign kf_full = {33'b0, kest_reg} * {26'b0, FULL_TURN};
    assign r_next  = q2_reg - kf_reg;

    always_comb
    begin
        if (r_reg >= {1'b0, FULL_TURN, 1'b0})
            r_fix = r_reg - {1'b0, FULL_TURN, 1'b0};
        else if (r_reg >= {2'b0, FULL_TURN})
            r_fix = r_reg - {2'b0, FULL_TURN};
        else
            r_fix = r_reg;
        // An angle of exactly one full turn is kept unreduced.
        a_next = eq3_reg ? FULL_TURN : r_fix[ANGLE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvld_reg <= '0;
        end
        else
        begin
            mvld_reg <= {mvld_reg[2:0], dvld_reg[DIV_DIGITS-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        kest_reg <= kprod[57:32];
        q1_reg   <= q;
        eq1_reg  <= q == {25'b0, FULL_TURN};
        kf_reg   <= kf_full[34:0];
        q2_reg   <= q1_reg[34:0];
        eq2_reg  <= eq1_reg;
        r_reg    <= r_next;
        eq3_reg  <= eq2_reg;
        a_reg    <= a_next;
    end

    logic [ANGLE_W-1:0] ang;
    logic               neg;
    logic               fold_vld_reg;
    logic               fold_neg_reg;
    logic [30:0]        fold_ang_reg;

    always_comb
    begin
        if (a_reg <= HALF_PI)
        begin
            ang = a_reg;
            neg = 1'b0;
        end
        else if (a_reg <= PI_Q30)
        begin
            ang = PI_Q30 - a_reg;
            neg = 1'b0;
        end
        else if (a_reg <= PI3_2_Q30)
        begin
            ang = a_reg - PI_Q30;
            neg = 1'b1;
        end
        else
        begin
            ang = FULL_TURN - a_reg;
            neg = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_vld_reg <= 1'b0;
        end
        else
        begin
            fold_vld_reg <= mvld_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        fold_neg_reg <= neg;
        fold_ang_reg <= ang[30:0];
    end

    assign fold.valid = fold_vld_reg;
    assign fold.neg   = fold_neg_reg;
    assign fold.angle = fold_ang_reg;

endmodule

FILE: hdl/csg_cordic.sv
module csg_cordic import csg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  fold_t       fold,
    output cordic_out_t result
);

    logic signed [CORDIC_W-1:0] x_reg   [ROT_STEPS];
    logic signed [CORDIC_W-1:0] y_reg   [ROT_STEPS];
    logic signed [CORDIC_W-1:0] z_reg   [ROT_STEPS];
    logic                       neg_reg [ROT_STEPS];
    logic                       vld_reg [ROT_STEPS];

    genvar k;
    generate
        for (k = 0; k < ROT_STEPS; k++) begin : g_step
            logic signed [CORDIC_W-1:0] x_in;
            logic signed [CORDIC_W-1:0] y_in;
            logic signed [CORDIC_W-1:0] z_in;
            logic                       n_in;
            logic                       v_in;
            logic signed [CORDIC_W-1:0] dx;
            logic signed [CORDIC_W-1:0] dy;
            logic signed [CORDIC_W-1:0] dz;
            if (k == 0) begin : g_first
                assign x_in = INV_GAIN;
                assign y_in = '0;
                assign z_in = {3'b0, fold.angle};
                assign n_in = fold.neg;
                assign v_in = fold.valid;
            end else begin : g_rest
                assign x_in = x_reg[k-1];
                assign y_in = y_reg[k-1];
                assign z_in = z_reg[k-1];
                assign n_in = neg_reg[k-1];
                assign v_in = vld_reg[k-1];
            end
            assign dx = y_in >>> k;
            assign dy = x_in >>> k;
            assign dz = {4'b0, atan_q30(k)};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else
                begin
                    vld_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (!z_in[CORDIC_W-1])
                begin
                    x_reg[k] <= x_in - dx;
                    y_reg[k] <= y_in + dy;
                    z_reg[k] <= z_in - dz;
                end
                else
                begin
                    x_reg[k] <= x_in + dx;
                    y_reg[k] <= y_in - dy;
                    z_reg[k] <= z_in + dz;
                end
                neg_reg[k] <= n_in;
            end
        end
    endgenerate

    assign result.valid = vld_reg[ROT_STEPS-1];
    assign result.neg   = neg_reg[ROT_STEPS-1];
    assign result.sine  = y_reg[ROT_STEPS-1];

endmodule

FILE: hdl/csg_scale.sv
module csg_scale import csg_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cordic_out_t                sine,
    input  logic [AMP_W-1:0]           amplitude,
    output logic                       out_valid,
    output logic signed [SAMPLE_W-1:0] value
);

    localparam int PROD_W = CORDIC_W + AMP_W + 1;

    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic                       neg_reg;
    logic [1:0]                 vld_reg;
    logic [PROD_W-1:0]          abs_prod;
    logic [PROD_W-31:0]         mag;
    logic                       sgn;
    logic signed [SAMPLE_W-1:0] value_reg, value_next;

    assign prod_next = sine.sine * $signed({1'b0, amplitude});

    // Truncation toward zero: shift the magnitude, then restore the sign.
    assign abs_prod = prod_reg[PROD_W-1] ? 50'(-prod_reg) : prod_reg;
    assign mag      = abs_prod[PROD_W-1:30];
    assign sgn      = prod_reg[PROD_W-1] ^ neg_reg;

    always_comb
    begin
        if (!sgn)
        begin
            if (mag > 20'(SAMPLE_MAX))
                value_next = SAMPLE_MAX;
            else
                value_next = mag[SAMPLE_W-1:0];
        end
        else
        begin
            if (mag > 20'd32767)
                value_next = SAMPLE_MIN;
            else
                value_next = -$signed(mag[SAMPLE_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[0], sine.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        neg_reg   <= sine.neg;
        value_reg <= value_next;
    end

    assign out_valid = vld_reg[1];
    assign value     = value_reg;

endmodule

FILE: hdl/cordic_sine_sample_generator.sv
// Channel   Handshake             Word
// input     start (busy low)      sample_index
// result    sample_valid          sample_value
// config    cfg_write             cfg_index, cfg_data
//
// Each index passes through a 98-stage pipeline: a bit-per-stage division by the sample
// rate (47), the frequency and 355 multiplies (4), division by 113 in 16-bit digits (8),
// reduction by a full turn and the quadrant fold (5), one CORDIC rotation per stage (32)
// and the amplitude scaling (2).
// One word is accepted every cycle, and its sample leaves the last stage of the pipeline.
// Reset clears all valid flags and restores the default register values.
// busy is never raised and results cannot be held off.
module cordic_sine_sample_generator import csg_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [INDEX_W-1:0]         sample_index,
    output logic                       sample_valid,
    output logic signed [SAMPLE_W-1:0] sample_value,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DAT_W-1:0]       cfg_data
);

    logic [FREQ_W-1:0]  tone_frequency_reg;
    logic [RATE_W-1:0]  sample_rate_reg;
    logic [AMP_W-1:0]   amplitude_reg;
    logic               accept;
    logic               phase_valid;
    logic [PHASE_W-1:0] phase;
    fold_t              fold;
    cordic_out_t        sine;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_frequency_reg <= 15'd1000;
            sample_rate_reg    <= 18'd48000;
            amplitude_reg      <= 15'd16384;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TONE: tone_frequency_reg <= cfg_data[FREQ_W-1:0];
                REG_RATE: sample_rate_reg    <= cfg_data[RATE_W-1:0];
                REG_AMP:  amplitude_reg      <= cfg_data[AMP_W-1:0];
                default:  ;
            endcase
        end
    end

    csg_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .index     (sample_index),
        .rate      (sample_rate_reg),
        .freq      (tone_frequency_reg),
        .out_valid (phase_valid),
        .phase     (phase)
    );

    csg_reduce u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (phase_valid),
        .phase    (phase),
        .fold     (fold)
    );

    csg_cordic u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .fold   (fold),
        .result (sine)
    );

    csg_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .sine      (sine),
        .amplitude (amplitude_reg),
        .out_valid (sample_valid),
        .value     (sample_value)
    );

    // Every accepted word produces a sample after the fixed pipeline latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##PIPE_LATENCY sample_valid)
        else $error("sample missing after pipeline latency");

    // The most negative code is never produced.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid |-> sample_value != 16'sh8000)
        else $error("sample outside saturation range");

    // Zero amplitude gives silence.
    a_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && amplitude_reg == '0) |-> sample_value == '0)
        else $error("non-zero sample at zero amplitude");

    // The folded angle never exceeds a quarter turn.
    a_fold: assert property (@(posedge clk) disable iff (!rst_n)
        fold.valid |-> {2'b0, fold.angle} <= HALF_PI)
        else $error("folded angle beyond a quarter turn");

endmodule
